// ----- rtl/core/gjtm_pkg.sv -----
// Shared types and constants for the gamepad to joypad turbo mapper.
package gjtm_pkg;

   // Field widths of the request and response transactions
   localparam int PAD_INDEX_W    = 2;
   localparam int BUTTONS_W      = 10;
   localparam int STICK_W        = 8;
   localparam int JOYPAD_W       = 8;

   // Configuration port
   localparam int CSR_INDEX_W    = 1;
   localparam int CSR_DATA_W     = 7;
   localparam int TURBO_W        = 4;
   localparam int RADIUS_W       = 7;

   localparam logic [CSR_INDEX_W-1:0] CSR_TURBO_PERIOD    = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEADZONE_RADIUS = 1'd1;

   localparam logic [TURBO_W-1:0]  TURBO_PERIOD_RESET    = 4'd2;
   localparam logic [RADIUS_W-1:0] DEADZONE_RADIUS_RESET = 7'd70;

   // Sector slope, 2.414 in 8-bit fixed point
   localparam int K_NUM   = 618;
   localparam int K_SHIFT = 8;

   // Stick magnitude, squares and sums
   localparam int MAG_W   = 8;
   localparam int SQ_W    = 2 * MAG_W;
   localparam int SLOPE_W = 17;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SQX,
      ST_SQY,
      ST_FIN
   } state_type;

   // Operand select of the shared multiplier
   typedef enum logic [1:0] {
      SEL_X,
      SEL_Y,
      SEL_R
   } mul_sel_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic        load_item;
      logic        acc_load;
      logic        acc_add;
      logic        finish;
      mul_sel_type mul_sel;
   } cmd_type;

endpackage

// ----- rtl/core/gjtm_req_if.sv -----
// Request channel: one poll of one pad.
interface gjtm_req_if;
   import gjtm_pkg::*;

   logic                          valid;
   logic                          ready;
   logic        [PAD_INDEX_W-1:0] pad_index;
   logic        [BUTTONS_W-1:0]   buttons_held;
   logic signed [STICK_W-1:0]     stick_x;
   logic signed [STICK_W-1:0]     stick_y;

   modport source (output valid, pad_index, buttons_held, stick_x, stick_y, input ready);
   modport sink   (input valid, pad_index, buttons_held, stick_x, stick_y, output ready);
endinterface

// ----- rtl/core/gjtm_rsp_if.sv -----
// Response channel: pad number and joypad byte.
interface gjtm_rsp_if;
   import gjtm_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [PAD_INDEX_W-1:0] pad_number;
   logic [JOYPAD_W-1:0]    joypad_byte;

   modport source (output valid, pad_number, joypad_byte, input ready);
   modport sink   (input valid, pad_number, joypad_byte, output ready);
endinterface

// ----- rtl/core/gamepad_to_joypad_turbo_mapper.sv -----
// Top level of the gamepad to joypad turbo mapper.
//
// Channels: req_if carries one poll of one pad (pad index, ten held buttons,
// signed stick X/Y); rsp_if returns the pad number and the 8-bit joypad byte
// (A, B, Select, Start, Up, Down, Left, Right). Both use valid/ready.
// The csr_ port writes turbo_period (index 0) and deadzone_radius (index 1).
//
// Each accepted transaction is sequenced through the states SQX, SQY and
// FIN into the output register, and the next poll is accepted only once
// the sequencer is back in idle. The datapath has a single 8x8 multiplier,
// used once for each of x squared, y squared and the dead-zone radius squared.
// The output register lets the next poll be accepted and squared while a
// result still waits; a stalled receiver holds the sequencer in its final
// step once the following result is ready.
//
// Reset clears the turbo counters and held flags of every pad, empties the
// output register and loads turbo_period 2 and deadzone_radius 70.
module gamepad_to_joypad_turbo_mapper #(
   parameter int PAD_COUNT = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   gjtm_req_if.sink                          req_if,
   gjtm_rsp_if.source                        rsp_if,
   input  logic                              csr_write_enable,
   input  logic [gjtm_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [gjtm_pkg::CSR_DATA_W-1:0]   csr_write_data
);
   import gjtm_pkg::*;

   cmd_type cmd;

   // Sequencer
   gjtm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .cmd       (cmd)
   );

   // Datapath
   gjtm_datapath #(
      .PAD_COUNT (PAD_COUNT)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_pad_index    (req_if.pad_index),
      .req_buttons_held (req_if.buttons_held),
      .req_stick_x      (req_if.stick_x),
      .req_stick_y      (req_if.stick_y),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_pad_number   (rsp_if.pad_number),
      .rsp_joypad_byte  (rsp_if.joypad_byte)
   );

endmodule

// ----- rtl/core/gjtm_datapath.sv -----
// Datapath: turbo counters, configuration, shared multiplier, sector logic, output register.
module gjtm_datapath #(
   parameter int PAD_COUNT = 4
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  gjtm_pkg::cmd_type                       cmd,
   input  logic        [gjtm_pkg::PAD_INDEX_W-1:0] req_pad_index,
   input  logic        [gjtm_pkg::BUTTONS_W-1:0]   req_buttons_held,
   input  logic signed [gjtm_pkg::STICK_W-1:0]     req_stick_x,
   input  logic signed [gjtm_pkg::STICK_W-1:0]     req_stick_y,
   input  logic                                    csr_write_enable,
   input  logic        [gjtm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic        [gjtm_pkg::CSR_DATA_W-1:0]  csr_write_data,
   output logic        [gjtm_pkg::PAD_INDEX_W-1:0] rsp_pad_number,
   output logic        [gjtm_pkg::JOYPAD_W-1:0]    rsp_joypad_byte
);
   import gjtm_pkg::*;

   localparam int IDX_W = (PAD_COUNT > 1) ? $clog2(PAD_COUNT) : 1;

   typedef struct packed {
      logic               ok;
      logic [TURBO_W-1:0] next;
   } lane_type;

   // One turbo lane: may the button count, and the counter's next value
   function automatic lane_type turbo_lane(input logic [TURBO_W-1:0] count,
                                           input logic held_before,
                                           input logic [TURBO_W-1:0] period);
      lane_type             r;
      logic [TURBO_W-1:0]   c;
      r.ok = (count == '0) || !held_before;
      c    = r.ok ? period : count;
      r.next = (c != '0) ? c - TURBO_W'(1) : c;
      return r;
   endfunction

   // Configuration registers
   logic [TURBO_W-1:0]  turbo_period_ff;
   logic [RADIUS_W-1:0] deadzone_radius_ff;

   // Per-pad turbo state
   logic [TURBO_W-1:0] turbo_a_count_ff [PAD_COUNT];
   logic [TURBO_W-1:0] turbo_b_count_ff [PAD_COUNT];
   logic [1:0]         prev_turbo_held_ff [PAD_COUNT];

   // Item registers
   logic        [PAD_INDEX_W-1:0] pad_ff;
   logic        [JOYPAD_W-1:0]    base_byte_ff, base_byte_in;
   logic signed [STICK_W-1:0]     x_ff, y_ff;
   logic        [SQ_W-1:0]        acc_ff;
   logic        [PAD_INDEX_W-1:0] pad_number_ff;
   logic        [JOYPAD_W-1:0]    joypad_byte_ff, joypad_byte_in;

   logic               in_range;
   logic [IDX_W-1:0]   idx;
   logic [TURBO_W-1:0] cnt_a, cnt_b;
   logic [1:0]         held_prev;
   lane_type           lane_a, lane_b;

   logic [MAG_W-1:0]   ax, ay, op;
   logic [SQ_W-1:0]    prod;
   logic [SLOPE_W-1:0] kx, ky, sx, sy;
   logic               outside, x_zero, y_zero, x_pos, y_pos;
   logic [JOYPAD_W-1:0] dir;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         turbo_period_ff    <= TURBO_PERIOD_RESET;
         deadzone_radius_ff <= DEADZONE_RADIUS_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_TURBO_PERIOD:    turbo_period_ff    <= csr_write_data[TURBO_W-1:0];
            CSR_DEADZONE_RADIUS: deadzone_radius_ff <= csr_write_data[RADIUS_W-1:0];
            default: ;
         endcase
      end
   end

   // Read the polled pad's turbo state
   assign in_range  = 32'(req_pad_index) < PAD_COUNT;
   assign idx       = req_pad_index[IDX_W-1:0];
   assign cnt_a     = in_range ? turbo_a_count_ff[idx]   : '0;
   assign cnt_b     = in_range ? turbo_b_count_ff[idx]   : '0;
   assign held_prev = in_range ? prev_turbo_held_ff[idx] : '0;
   assign lane_a    = turbo_lane(cnt_a, held_prev[0], turbo_period_ff);
   assign lane_b    = turbo_lane(cnt_b, held_prev[1], turbo_period_ff);

   // Advance the polled pad's turbo state on acceptance
   always_ff @(posedge clock) begin
      for (int i = 0; i < PAD_COUNT; i++) begin
         if (reset) begin
            turbo_a_count_ff[i]   <= '0;
            turbo_b_count_ff[i]   <= '0;
            prev_turbo_held_ff[i] <= '0;
         end else if (cmd.load_item && in_range && (idx == IDX_W'(i))) begin
            turbo_a_count_ff[i]   <= lane_a.next;
            turbo_b_count_ff[i]   <= lane_b.next;
            prev_turbo_held_ff[i] <= req_buttons_held[5:4];
         end
      end
   end

   // Map buttons to the joypad byte
   always_comb begin
      base_byte_in[0] = req_buttons_held[0] | (req_buttons_held[4] & lane_a.ok);
      base_byte_in[1] = req_buttons_held[1] | (req_buttons_held[5] & lane_b.ok);
      base_byte_in[2] = req_buttons_held[3];
      base_byte_in[3] = req_buttons_held[2];
      base_byte_in[4] = req_buttons_held[6];
      base_byte_in[5] = req_buttons_held[7];
      base_byte_in[6] = req_buttons_held[8];
      base_byte_in[7] = req_buttons_held[9];
   end

   // Capture the item
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         pad_ff       <= req_pad_index;
         base_byte_ff <= base_byte_in;
         x_ff         <= req_stick_x;
         y_ff         <= req_stick_y;
      end
   end

   // Shared multiplier: x squared, y squared, radius squared
   assign ax = x_ff[STICK_W-1] ? $unsigned(-x_ff) : $unsigned(x_ff);
   assign ay = y_ff[STICK_W-1] ? $unsigned(-y_ff) : $unsigned(y_ff);

   always_comb begin
      unique case (cmd.mul_sel)
         SEL_X:   op = ax;
         SEL_Y:   op = ay;
         SEL_R:   op = MAG_W'(deadzone_radius_ff);
         default: op = '0;
      endcase
   end

   assign prod = SQ_W'(op) * SQ_W'(op);

   // Accumulate the squared magnitude
   always_ff @(posedge clock) begin
      if (cmd.acc_load) begin
         acc_ff <= prod;
      end else if (cmd.acc_add) begin
         acc_ff <= acc_ff + prod;
      end
   end

   // Sector tests against the fixed-point slope
   assign kx      = SLOPE_W'(ax) * SLOPE_W'(K_NUM);
   assign ky      = SLOPE_W'(ay) * SLOPE_W'(K_NUM);
   assign sx      = SLOPE_W'(ax) << K_SHIFT;
   assign sy      = SLOPE_W'(ay) << K_SHIFT;
   assign outside = acc_ff > prod;
   assign x_zero  = (x_ff == '0);
   assign y_zero  = (y_ff == '0);
   assign x_pos   = !x_ff[STICK_W-1] && !x_zero;
   assign y_pos   = !y_ff[STICK_W-1] && !y_zero;

   always_comb begin
      dir = '0;
      if (outside) begin
         if (y_zero) begin
            dir[7] = x_pos;
            dir[6] = !x_pos;
         end else if (x_zero) begin
            dir[4] = y_pos;
            dir[5] = !y_pos;
         end else begin
            if (sy < kx) begin
               dir[7] = x_pos;
               dir[6] = !x_pos;
            end
            if (sx < ky) begin
               dir[4] = y_pos;
               dir[5] = !y_pos;
            end
         end
      end
   end

   assign joypad_byte_in = base_byte_ff | dir;

   // Output register
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         pad_number_ff  <= pad_ff;
         joypad_byte_ff <= joypad_byte_in;
      end
   end

   assign rsp_pad_number  = pad_number_ff;
   assign rsp_joypad_byte = joypad_byte_ff;

endmodule

// ----- rtl/core/gjtm_ctrl.sv -----
// Controller: sequencer state machine and response valid flag.
module gjtm_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output gjtm_pkg::cmd_type cmd
);
   import gjtm_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_SQX;
         ST_SQX:  state_in = ST_SQY;
         ST_SQY:  state_in = ST_FIN;
         ST_FIN:  if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      req_ready     = 1'b0;
      cmd.load_item = 1'b0;
      cmd.acc_load  = 1'b0;
      cmd.acc_add   = 1'b0;
      cmd.finish    = 1'b0;
      cmd.mul_sel   = SEL_X;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready     = 1'b1;
            cmd.load_item = req_valid;
         end
         ST_SQX: begin
            cmd.mul_sel  = SEL_X;
            cmd.acc_load = 1'b1;
         end
         ST_SQY: begin
            cmd.mul_sel = SEL_Y;
            cmd.acc_add = 1'b1;
         end
         ST_FIN: begin
            cmd.mul_sel = SEL_R;
            cmd.finish  = out_free;
         end
         default: ;
      endcase
   end

   // Hold the response until taken
   assign rsp_valid_in = cmd.finish ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_finish_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_valid_ff || rsp_ready))
      else $error("result loaded over an untaken result");

   a_finish_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid_ff)
      else $error("finished result not presented");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_SQX))
      else $error("accepted transaction did not start the sequence");

   a_sqx_to_sqy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SQX) |=> (state_ff == ST_SQY))
      else $error("sequencer skipped the second square");

endmodule
